[src/epoch_to_calendar_defines.svh]
// ----------------------------------------------------------------------------
// epoch_to_calendar assertion macros
// Shared concurrent assertion forms for the epoch to calendar block.
// ----------------------------------------------------------------------------
`ifndef EPOCH_TO_CALENDAR_DEFINES_SVH
`define EPOCH_TO_CALENDAR_DEFINES_SVH

// same-cycle implication, off while reset is held
`define ECAL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, always active
`define ECAL_ASSERT_NXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ecal_pkg.sv]
// ----------------------------------------------------------------------------
// ecal_pkg
// Types and constants shared by the epoch to calendar pipeline.
// ----------------------------------------------------------------------------
package ecal_pkg;

    localparam int unsigned LATENCY = 7;

    // 1901-01-01 is the first day of the covered four-year cycles
    localparam logic [10:0] YEAR_BASE = 11'd1901;

    typedef logic [8:0] t_mstart;

    localparam t_mstart MONTH_START [2][13] = '{
        '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
          9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365},
        '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
          9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366}
    };

    typedef struct packed {
        logic        valid;
        logic [15:0] days_1901;   // days since 1901-01-01
        logic [15:0] wd_acc;      // weekday is this value mod 7
        logic [16:0] sod;         // second of day
    } t_split;

    typedef struct packed {
        logic [10:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [2:0]  weekday;
        logic [8:0]  day_of_year;
    } t_date;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod;

endpackage

[src/ecal_split.sv]
// ----------------------------------------------------------------------------
// ecal_split
// Splits a signed epoch into a day index and a second of day (3 stages).
// ----------------------------------------------------------------------------
module ecal_split (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [31:0]    i_epoch,
    output ecal_pkg::t_split      o_split
);

    // epoch + 24856 days keeps the value non-negative and day aligned
    localparam logic [32:0] EPOCH_BIAS = 33'd74752;
    // floor(x / 675) = (x * DAY_RECIP) >> 36 for x < 2^26
    localparam logic [26:0] DAY_RECIP  = 27'd101806633;

    logic [32:0] n_biased;
    logic [52:0] n_prod;
    logic [25:0] n_rem;

    logic        r_v1, r_v2, r_v3;
    logic [25:0] r_w1, r_w2;
    logic [6:0]  r_lo1, r_lo2;
    logic [15:0] r_q2;
    logic [15:0] r_days3;
    logic [15:0] r_wd3;
    logic [16:0] r_sod3;

    assign n_biased = {1'b0, ~i_epoch[31], i_epoch[30:0]} + EPOCH_BIAS;
    assign n_prod   = 53'(r_w1) * 53'(DAY_RECIP);
    assign n_rem    = r_w2 - 26'(r_q2) * 26'd675;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w1    <= n_biased[32:7];
        r_lo1   <= n_biased[6:0];
        r_q2    <= n_prod[51:36];
        r_w2    <= r_w1;
        r_lo2   <= r_lo1;
        r_days3 <= r_q2 + 16'd346;
        r_wd3   <= r_q2 + 16'd5;
        r_sod3  <= {n_rem[9:0], r_lo2};
    end

    assign o_split = {r_v3, r_days3, r_wd3, r_sod3};

endmodule

[src/ecal_date.sv]
// ----------------------------------------------------------------------------
// ecal_date
// Day index to year, month, day, weekday and day of year (4 stages).
// ----------------------------------------------------------------------------
module ecal_date (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [15:0]       i_days_1901,
    input  logic [15:0]       i_wd_acc,
    output logic              o_valid,
    output ecal_pkg::t_date   o_date
);

    // floor(d / 1461) = (d * CYC_RECIP) >> 27 for d < 2^16
    localparam logic [16:0] CYC_RECIP = 17'd91868;
    // floor(x / 7) = (x * WK_RECIP) >> 19 for x < 2^16
    localparam logic [16:0] WK_RECIP  = 17'd74899;

    logic [32:0] n_cprod, n_wprod;
    logic [15:0] n_r, n_wd;
    logic [1:0]  n_yi;
    logic [10:0] n_yday;
    logic [10:0] n_year;
    logic [3:0]  n_midx;
    logic [8:0]  n_start;
    logic [8:0]  n_dom;

    logic        r_v4, r_v5, r_v6, r_v7;
    logic [5:0]  r_q4, r_q4_5;
    logic [12:0] r_q7;
    logic [15:0] r_d0_4, r_x4;
    logic [10:0] r_r5;
    logic [2:0]  r_wd5, r_wd6;
    logic [10:0] r_year6;
    logic [8:0]  r_yday6;
    logic        r_leap6;
    ecal_pkg::t_date r_date;

    assign n_cprod = 33'(i_days_1901) * 33'(CYC_RECIP);
    assign n_wprod = 33'(i_wd_acc) * 33'(WK_RECIP);

    assign n_r  = r_d0_4 - 16'(r_q4) * 16'd1461;
    assign n_wd = r_x4 - 16'(r_q7) * 16'd7;

    always_comb begin
        if (r_r5 >= 11'd1095) begin
            n_yi = 2'd3;
        end else if (r_r5 >= 11'd730) begin
            n_yi = 2'd2;
        end else if (r_r5 >= 11'd365) begin
            n_yi = 2'd1;
        end else begin
            n_yi = 2'd0;
        end
    end

    assign n_yday = r_r5 - 11'(n_yi) * 11'd365;
    assign n_year = ecal_pkg::YEAR_BASE + 11'({r_q4_5, 2'b00}) + 11'(n_yi);

    always_comb begin
        n_midx = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (r_yday6 >= ecal_pkg::MONTH_START[r_leap6][i]) begin
                n_midx = 4'(i);
            end
        end
    end

    assign n_start = ecal_pkg::MONTH_START[r_leap6][n_midx];
    assign n_dom   = r_yday6 - n_start + 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q4                <= n_cprod[32:27];
        r_q7                <= n_wprod[31:19];
        r_d0_4              <= i_days_1901;
        r_x4                <= i_wd_acc;
        r_r5                <= n_r[10:0];
        r_q4_5              <= r_q4;
        r_wd5               <= n_wd[2:0];
        r_year6             <= n_year;
        r_yday6             <= n_yday[8:0];
        r_leap6             <= (n_yi == 2'd3);
        r_wd6               <= r_wd5;
        r_date.year         <= r_year6;
        r_date.month        <= n_midx + 4'd1;
        r_date.day_of_month <= n_dom[4:0];
        r_date.weekday      <= r_wd6;
        r_date.day_of_year  <= r_yday6;
    end

    assign o_valid = r_v7;
    assign o_date  = r_date;

endmodule

[src/ecal_tod.sv]
// ----------------------------------------------------------------------------
// ecal_tod
// Second of day to hour, minute and second (4 stages).
// ----------------------------------------------------------------------------
module ecal_tod (
    input  logic             i_clk,
    input  logic [16:0]      i_sod,
    output ecal_pkg::t_tod   o_tod
);

    // floor(x / 225) = (x * HR_RECIP) >> 21 for x < 2^13
    localparam logic [13:0] HR_RECIP  = 14'd9321;
    // floor(x / 15) = (x * MIN_RECIP) >> 14 for x < 2^10
    localparam logic [10:0] MIN_RECIP = 11'd1093;

    logic [26:0] n_hprod;
    logic [16:0] n_remh;
    logic [20:0] n_mprod;
    logic [11:0] n_sec;

    logic [4:0]  r_hour4, r_hour5, r_hour6;
    logic [16:0] r_sod4;
    logic [11:0] r_remh5, r_remh6;
    logic [5:0]  r_min6;
    ecal_pkg::t_tod r_tod;

    assign n_hprod = 27'(i_sod[16:4]) * 27'(HR_RECIP);
    assign n_remh  = r_sod4 - 17'(r_hour4) * 17'd3600;
    assign n_mprod = 21'(r_remh5[11:2]) * 21'(MIN_RECIP);
    assign n_sec   = r_remh6 - 12'(r_min6) * 12'd60;

    always_ff @(posedge i_clk) begin
        r_hour4      <= n_hprod[25:21];
        r_sod4       <= i_sod;
        r_remh5      <= n_remh[11:0];
        r_hour5      <= r_hour4;
        r_min6       <= n_mprod[19:14];
        r_remh6      <= r_remh5;
        r_hour6      <= r_hour5;
        r_tod.hour   <= r_hour6;
        r_tod.minute <= r_min6;
        r_tod.second <= n_sec[5:0];
    end

    assign o_tod = r_tod;

endmodule

[src/epoch_to_calendar.sv]
// A result strobes on o_done when its start transaction leaves the last of the seven register stages.
// Throughput: one transaction per cycle; seven register stages, some with
// more than one constant-reciprocal multiply or multiply-subtract.
// busy is high only while i_rst_n is low; results cannot be stalled.
// Synchronous reset clears every stage valid bit, dropping work in flight.
// ----------------------------------------------------------------------------
// epoch_to_calendar
// Signed Unix epoch seconds to UTC calendar date and time of day.
// ----------------------------------------------------------------------------
`include "epoch_to_calendar_defines.svh"

module epoch_to_calendar (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_epoch_seconds,
    output logic               o_done,
    output logic [10:0]        o_year,
    output logic [3:0]         o_month,
    output logic [4:0]         o_day_of_month,
    output logic [4:0]         o_hour,
    output logic [5:0]         o_minute,
    output logic [5:0]         o_second,
    output logic [2:0]         o_weekday,
    output logic [8:0]         o_day_of_year
);

    ecal_pkg::t_split split;
    ecal_pkg::t_date  date;
    ecal_pkg::t_tod   tod;

    assign busy = ~i_rst_n;

    ecal_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_epoch (i_epoch_seconds),
        .o_split (split)
    );

    ecal_date u_date (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (split.valid),
        .i_days_1901 (split.days_1901),
        .i_wd_acc    (split.wd_acc),
        .o_valid     (o_done),
        .o_date      (date)
    );

    ecal_tod u_tod (
        .i_clk (i_clk),
        .i_sod (split.sod),
        .o_tod (tod)
    );

    assign o_year         = date.year;
    assign o_month        = date.month;
    assign o_day_of_month = date.day_of_month;
    assign o_weekday      = date.weekday;
    assign o_day_of_year  = date.day_of_year;
    assign o_hour         = tod.hour;
    assign o_minute       = tod.minute;
    assign o_second       = tod.second;

    `ECAL_ASSERT_IMP(a_done_has_start, i_clk, i_rst_n, o_done, $past(start && !busy, ecal_pkg::LATENCY), "result without a matching start transaction")
    `ECAL_ASSERT_IMP(a_date_range, i_clk, i_rst_n, o_done, (o_month >= 4'd1) && (o_month <= 4'd12) && (o_day_of_month >= 5'd1) && (o_day_of_year <= 9'd365) && (o_year >= 11'd1901) && (o_year <= 11'd2038), "date field out of range")
    `ECAL_ASSERT_IMP(a_tod_range, i_clk, i_rst_n, o_done, (o_hour <= 5'd23) && (o_minute <= 6'd59) && (o_second <= 6'd59) && (o_weekday <= 3'd6), "time or weekday field out of range")
    `ECAL_ASSERT_NXT(a_reset_flush, i_clk, !i_rst_n, !o_done, "result strobe right after reset")

endmodule

[verif/epoch_to_calendar_tb.sv]
// ----------------------------------------------------------------------------
// epoch_to_calendar_tb
// Self-checking bench for the epoch to calendar converter. A short table of
// hand-picked timestamps (range limits, day, month, year and leap-day edges,
// negative epochs) runs first, then about 1550 random timestamps mostly aimed at
// the same edges. Each transaction is predicted with floor-division
// arithmetic and checked field by field against the strobed result, in order.
// The sender runs in random bursts with random gaps.
// ----------------------------------------------------------------------------
module epoch_to_calendar_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     PIPE_DEPTH     = 7;
    localparam int     WATCHDOG_LIMIT = 1000;
    localparam int     RANDOM_ITEMS   = 1550;
    localparam int     EPOCH_YEAR     = 1970;
    localparam longint HOUR_LEN_S     = 60 * 60;
    localparam longint DAY_LEN_S      = HOUR_LEN_S * 24;

    localparam int MONTH_FIRST [2][13] = '{
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365},
        '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366}
    };

    typedef struct packed {
        logic [10:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic [8:0]  day_of_year;
    } calendar_t;

    typedef struct packed {
        logic signed [31:0] epoch;
        calendar_t          date;
    } stamp_t;

    typedef struct packed {
        logic signed [31:0] epoch;
        logic               typed;
        calendar_t          date;
    } table_row_t;

    localparam int N_ROWS = 20;
    localparam table_row_t STAMP_TABLE [N_ROWS] = '{
        '{32'sd0,           1'b1, '{11'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  3'd4, 9'd0}},
        '{-32'sd1,          1'b1, '{11'd1969, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 3'd3, 9'd364}},
        '{32'sd2147483647,  1'b1, '{11'd2038, 4'd1,  5'd19, 5'd3,  6'd14, 6'd7,  3'd2, 9'd18}},
        '{-32'sd2147483648, 1'b1, '{11'd1901, 4'd12, 5'd13, 5'd20, 6'd45, 6'd52, 3'd5, 9'd346}},
        '{32'sd86400,       1'b1, '{11'd1970, 4'd1,  5'd2,  5'd0,  6'd0,  6'd0,  3'd5, 9'd1}},
        '{-32'sd86400,      1'b1, '{11'd1969, 4'd12, 5'd31, 5'd0,  6'd0,  6'd0,  3'd3, 9'd364}},
        '{32'sd31536000,    1'b1, '{11'd1971, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  3'd5, 9'd0}},
        '{32'sd86399,       1'b0, '0},
        '{-32'sd86401,      1'b0, '0},
        '{32'sd951782400,   1'b0, '0},
        '{32'sd946684799,   1'b0, '0},
        '{32'sd978220800,   1'b0, '0},
        '{32'sd68169600,    1'b0, '0},
        '{32'sd1234567890,  1'b0, '0},
        '{32'sd2147483646,  1'b0, '0},
        '{-32'sd2147483647, 1'b0, '0},
        '{-32'sd2145916800, 1'b0, '0},
        '{-32'sd631152000,  1'b0, '0},
        '{32'sd2145916799,  1'b0, '0},
        '{32'sd1709164800,  1'b0, '0}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] i_epoch_seconds = '0;
    logic               o_done;
    logic [10:0]        o_year;
    logic [3:0]         o_month;
    logic [4:0]         o_day_of_month;
    logic [4:0]         o_hour;
    logic [5:0]         o_minute;
    logic [5:0]         o_second;
    logic [2:0]         o_weekday;
    logic [8:0]         o_day_of_year;

    stamp_t staged_stamp = '0;
    stamp_t pending_dates [$];
    int     error_count = 0;
    int     quiet_cycles = 0;

    epoch_to_calendar i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_epoch_seconds (i_epoch_seconds),
        .o_done          (o_done),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second),
        .o_weekday       (o_weekday),
        .o_day_of_year   (o_day_of_year)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint floor_div(longint a, longint b);
        longint q = a / b;
        if ((a % b) < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint floor_mod(longint a, longint b);
        return a - floor_div(a, b) * b;
    endfunction

    function automatic bit leap_year(longint y);
        return floor_mod(y, 4) == 0 && (floor_mod(y, 100) != 0 || floor_mod(y, 400) == 0);
    endfunction

    function automatic longint leap_days_through(longint y);
        return floor_div(y, 4) - floor_div(y, 100) + floor_div(y, 400);
    endfunction

    function automatic longint jan1_epoch(longint y);
        return ((y - EPOCH_YEAR) * 365 + leap_days_through(y - 1)
                - leap_days_through(EPOCH_YEAR - 1)) * DAY_LEN_S;
    endfunction

    function automatic calendar_t utc_date(logic signed [31:0] secs);
        longint    days;
        longint    sod;
        longint    yr;
        longint    guess;
        longint    span;
        int        mon;
        bit        lp;
        calendar_t r;
        days = floor_div(longint'(secs), DAY_LEN_S);
        sod  = floor_mod(longint'(secs), DAY_LEN_S);
        r.weekday = 3'(floor_mod(days + 4, 7));
        yr = EPOCH_YEAR;
        for (int pass = 0; pass < 8; pass++) begin
            span = leap_year(yr) ? 366 : 365;
            if (days >= 0 && days < span) break;
            guess = yr + floor_div(days, 365);
            days  = days - ((guess - yr) * 365 + leap_days_through(guess - 1)
                    - leap_days_through(yr - 1));
            yr = guess;
        end
        r.year        = 11'(yr);
        r.day_of_year = 9'(days);
        lp  = leap_year(yr);
        mon = 11;
        while (mon > 0 && days < MONTH_FIRST[lp][mon]) mon--;
        r.month        = 4'(mon + 1);
        r.day_of_month = 5'(days - MONTH_FIRST[lp][mon] + 1);
        r.hour         = 5'(sod / HOUR_LEN_S);
        r.minute       = 6'((sod % HOUR_LEN_S) / 60);
        r.second       = 6'(sod % 60);
        return r;
    endfunction

    // random timestamps, mostly near day/month/year/leap-day/range edges
    function automatic logic signed [31:0] pick_epoch();
        longint t;
        longint yr;
        longint off;
        int     mon;
        int     kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: return $urandom;
            4, 5: begin
                yr  = $urandom_range(1902, 2037);
                mon = $urandom_range(0, 11);
                off = $urandom_range(0, 2 * DAY_LEN_S);
                t = jan1_epoch(yr) + MONTH_FIRST[leap_year(yr)][mon] * DAY_LEN_S
                    + off - DAY_LEN_S;
            end
            6: begin
                yr  = $urandom_range(1902, 2037);
                off = $urandom_range(0, 1200);
                t = jan1_epoch(yr) + off - 600;
            end
            7: begin
                off = $urandom_range(0, 10);
                t = floor_div(longint'($signed($urandom)), DAY_LEN_S) * DAY_LEN_S
                    + off - 5;
            end
            8: begin
                yr  = 1904 + 4 * $urandom_range(0, 33);
                off = $urandom_range(0, 2 * DAY_LEN_S);
                t = jan1_epoch(yr) + ($urandom_range(0, 1) ? 58 : 364) * DAY_LEN_S + off;
            end
            default: begin
                off = $urandom_range(0, 200000);
                t = $urandom_range(0, 1) ? 64'sd2147483647 - off : -64'sd2147483648 + off;
            end
        endcase
        if (t > 64'sd2147483647 || t < -64'sd2147483648) return $urandom;
        return t[31:0];
    endfunction

    task automatic report_mismatch(string what, longint got, longint want, logic [31:0] ep);
        $display("ERROR: %s got %0d want %0d (epoch %0d)", what, got, want, $signed(ep));
        error_count++;
    endtask

    task automatic compare_date(calendar_t got, stamp_t want);
        if (got.year != want.date.year)
            report_mismatch("year", got.year, want.date.year, want.epoch);
        if (got.month != want.date.month)
            report_mismatch("month", got.month, want.date.month, want.epoch);
        if (got.day_of_month != want.date.day_of_month)
            report_mismatch("day_of_month", got.day_of_month, want.date.day_of_month, want.epoch);
        if (got.hour != want.date.hour)
            report_mismatch("hour", got.hour, want.date.hour, want.epoch);
        if (got.minute != want.date.minute)
            report_mismatch("minute", got.minute, want.date.minute, want.epoch);
        if (got.second != want.date.second)
            report_mismatch("second", got.second, want.date.second, want.epoch);
        if (got.weekday != want.date.weekday)
            report_mismatch("weekday", got.weekday, want.date.weekday, want.epoch);
        if (got.day_of_year != want.date.day_of_year)
            report_mismatch("day_of_year", got.day_of_year, want.date.day_of_year, want.epoch);
    endtask

    always @(posedge i_clk) begin
        calendar_t got;
        logic      took;
        took = start && !busy;
        if (took) pending_dates.push_back(staged_stamp);
        if (o_done) begin
            got = '{o_year, o_month, o_day_of_month, o_hour, o_minute, o_second,
                    o_weekday, o_day_of_year};
            if (pending_dates.size() == 0)
                report_mismatch("unexpected result, year", got.year, 0, 32'd0);
            else
                compare_date(got, pending_dates.pop_front());
        end
        quiet_cycles = (took || o_done) ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("epoch_to_calendar: mismatch");
            $finish;
        end
    end

    task automatic send_stamp(logic signed [31:0] ep, calendar_t want);
        start           <= 1'b1;
        i_epoch_seconds <= ep;
        staged_stamp    <= '{ep, want};
        do @(posedge i_clk); while (busy);
    endtask

    task automatic hold_off(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_dates.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic signed [31:0] ep;
        int                 sent;
        int                 burst;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            send_stamp(STAMP_TABLE[r].epoch, STAMP_TABLE[r].typed ? STAMP_TABLE[r].date
                                                                 : utc_date(STAMP_TABLE[r].epoch));
            hold_off($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
        end
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(0, 3) == 0 ? $urandom_range(40, 150) : $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
                if (sent == RANDOM_ITEMS / 2) wait_drained();
                ep = pick_epoch();
                send_stamp(ep, utc_date(ep));
                sent++;
            end
            hold_off($urandom_range(1, 10));
        end

        wait_drained();
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
        if (pending_dates.size() != 0)
            report_mismatch("results never arrived", pending_dates.size(), 0, 32'd0);
        if (error_count == 0) begin
            $display("epoch_to_calendar: match");
        end else begin
            $display("epoch_to_calendar: mismatch");
        end
        $finish;
    end

endmodule

[epoch_to_calendar.f]
+incdir+src
src/ecal_pkg.sv
src/ecal_split.sv
src/ecal_date.sv
src/ecal_tod.sv
src/epoch_to_calendar.sv
verif/epoch_to_calendar_tb.sv
